// File: rtl/core/rbi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared widths, register indexes, face tables and pipeline word types for
// the ray/box intersection block.
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int DW      = 32;          // coordinate width
    localparam int PW      = 2 * DW;      // offset product width
    localparam int QB      = 35;          // quotient bits kept (clamp at 2^34)
    localparam int RW      = PW + 3;      // divider remainder / compare width
    localparam int DIV_LAT = QB + 1;      // divider pipeline depth in stages
    localparam int PTW     = QB + 2;      // crossing point width before check
    localparam int CFG_IW  = 3;
    localparam int NFACE   = 6;

    localparam logic [QB-1:0] QCLAMP = QB'(1) << (QB - 1);

    typedef enum logic [CFG_IW-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    // face order: min x, min y, min z, max x, max y, max z
    localparam int AXIS [NFACE] = '{0, 1, 2, 0, 1, 2};
    localparam int OTH0 [NFACE] = '{1, 2, 0, 1, 2, 0};
    localparam int OTH1 [NFACE] = '{2, 0, 1, 2, 0, 1};

    typedef struct packed {
        logic          skip;
        logic          nneg;
        logic [DW-1:0] nmag;
        logic [DW-1:0] den;
        logic [1:0]    neg;
    } t_face;

    typedef struct packed {
        logic [2:0][DW-1:0]  org;
        t_face [NFACE-1:0]   face;
    } t_side;

    typedef struct packed {
        logic               v;
        logic               nneg;
        logic [DW-1:0]      nmag;
        logic [DW-1:0]      den;
        logic [2:0][DW-1:0] pt;
    } t_cand;

    // keep a unless b counts and a does not or b lies farther (b.t > a.t)
    // m1 = |num_b| * den_a, m2 = |num_a| * den_b
    function automatic t_cand pick(t_cand a, t_cand b, logic [PW-1:0] m1,
                                   logic [PW-1:0] m2);
        logic n1;
        logic n2;
        logic gt;
        n1 = b.nneg && (m1 != '0);
        n2 = a.nneg && (m2 != '0);
        if (n1 != n2) begin
            gt = n2;
        end else if (!n1) begin
            gt = m1 > m2;
        end else begin
            gt = m1 < m2;
        end
        if (b.v && (!a.v || gt)) begin
            return b;
        end
        return a;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ray_box_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_intersection
// Ray against an axis-aligned box: farthest crossing point on the six faces.
// ----------------------------------------------------------------------------
// Usage:
//   Box bounds are six 32-bit Q16.16 registers written through i_cfg_we /
//   i_cfg_idx / i_cfg_data (min x,y,z then max x,y,z); write them only while
//   no ray is in flight. A ray word (direction, origin) is taken on any edge
//   with i_start high and o_busy low. o_busy is high only during reset.
//   One ray is accepted every cycle. Each result word is shown for exactly
//   one cycle with o_done high. The latency is set by the 36-stage dividers
//   (a saturation check stage, then one quotient bit per stage), plus three
//   entry stages, two point/bound stages and a three-level compare tree of
//   two stages each.
//   Twelve dividers and multipliers work in parallel, so the rate is fixed.
//   The receiver cannot stall; results are never held.
//   Reset clears the box registers to zero and drops all words in flight.
//   On a miss o_hit is low and the point outputs are zero.
// ----------------------------------------------------------------------------
module ray_box_intersection import rbi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic signed [DW-1:0] i_dir_x,
    input  logic signed [DW-1:0] i_dir_y,
    input  logic signed [DW-1:0] i_dir_z,
    input  logic signed [DW-1:0] i_org_x,
    input  logic signed [DW-1:0] i_org_y,
    input  logic signed [DW-1:0] i_org_z,
    input  logic                 i_cfg_we,
    input  logic [CFG_IW-1:0]    i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data,
    output logic                 o_done,
    output logic                 o_hit,
    output logic signed [DW-1:0] o_hit_x,
    output logic signed [DW-1:0] o_hit_y,
    output logic signed [DW-1:0] o_hit_z
);

    localparam int LAT = 3 + DIV_LAT + 2 + 6;

    // box registers
    logic signed [DW-1:0] r_lo [0:2];
    logic signed [DW-1:0] r_hi [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_X: r_lo[0] <= i_cfg_data;
                CFG_MIN_Y: r_lo[1] <= i_cfg_data;
                CFG_MIN_Z: r_lo[2] <= i_cfg_data;
                CFG_MAX_X: r_hi[0] <= i_cfg_data;
                CFG_MAX_Y: r_hi[1] <= i_cfg_data;
                CFG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = !i_rst_n;

    // valid bits
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic [DIV_LAT-1:0]   r_dl_v;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_dl_v <= '0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_v9   <= 1'b0;
            r_v10  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start && !o_busy;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_dl_v <= {r_dl_v[DIV_LAT-2:0], r_v3};
            r_v4   <= r_dl_v[DIV_LAT-1];
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
            r_v8   <= r_v7;
            r_v9   <= r_v8;
            r_v10  <= r_v9;
            r_done <= r_v10;
        end
    end

    // stage 1: input word
    logic signed [DW-1:0] r_dir [0:2];
    logic signed [DW-1:0] r_org [0:2];

    always_ff @(posedge i_clk) begin
        r_dir[0] <= i_dir_x;
        r_dir[1] <= i_dir_y;
        r_dir[2] <= i_dir_z;
        r_org[0] <= i_org_x;
        r_org[1] <= i_org_y;
        r_org[2] <= i_org_z;
    end

    // stage 2: face numerators, denominators, signs
    t_side         n_side2;
    t_side         r_side2;
    logic [DW-1:0] n_dmag [0:2];
    logic [DW-1:0] r_dmag [0:2];

    always_comb begin
        logic signed [DW:0]   diff;
        logic signed [DW-1:0] bnd;
        logic                 nn;
        for (int a = 0; a < 3; a++) begin
            n_side2.org[a] = r_org[a];
            n_dmag[a] = r_dir[a][DW-1] ? DW'(-r_dir[a]) : DW'(r_dir[a]);
        end
        for (int f = 0; f < NFACE; f++) begin
            bnd  = (f < 3) ? r_lo[AXIS[f]] : r_hi[AXIS[f]];
            diff = {bnd[DW-1], bnd} - {r_org[AXIS[f]][DW-1], r_org[AXIS[f]]};
            nn   = (diff != '0) && (diff[DW] != r_dir[AXIS[f]][DW-1]);
            n_side2.face[f].skip   = r_dir[AXIS[f]] == '0;
            n_side2.face[f].nneg   = nn;
            n_side2.face[f].nmag   = diff[DW] ? DW'(-diff) : DW'(diff);
            n_side2.face[f].den    = n_dmag[AXIS[f]];
            n_side2.face[f].neg[0] = r_dir[OTH0[f]][DW-1] != nn;
            n_side2.face[f].neg[1] = r_dir[OTH1[f]][DW-1] != nn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2 <= n_side2;
        r_dmag  <= n_dmag;
    end

    // stage 3: offset products |dir_j| * |num|
    t_side         r_side3;
    logic [PW-1:0] r_prod [0:NFACE-1][0:1];

    always_ff @(posedge i_clk) begin
        r_side3 <= r_side2;
        for (int f = 0; f < NFACE; f++) begin
            r_prod[f][0] <= r_dmag[OTH0[f]] * r_side2.face[f].nmag;
            r_prod[f][1] <= r_dmag[OTH1[f]] * r_side2.face[f].nmag;
        end
    end

    // dividers and matching side line
    logic [QB-1:0] quot [0:NFACE-1][0:1];
    t_side         r_dl [0:DIV_LAT-1];

    for (genvar f = 0; f < NFACE; f++) begin : g_face
        for (genvar k = 0; k < 2; k++) begin : g_lane
            rbi_div u_div (
                .i_clk  (i_clk),
                .i_prod (r_prod[f][k]),
                .i_den  (r_side3.face[f].den),
                .o_quot (quot[f][k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl[0] <= r_side3;
        for (int d = 1; d < DIV_LAT; d++) begin
            r_dl[d] <= r_dl[d-1];
        end
    end

    // stage 4: crossing points
    t_side                 r_side4;
    logic signed [PTW-1:0] r_pt [0:NFACE-1][0:1];

    always_ff @(posedge i_clk) begin
        logic signed [PTW-1:0] oe;
        logic signed [PTW-1:0] qe;
        r_side4 <= r_dl[DIV_LAT-1];
        for (int f = 0; f < NFACE; f++) begin
            for (int k = 0; k < 2; k++) begin
                oe = PTW'($signed(r_dl[DIV_LAT-1].org[(k == 0) ? OTH0[f] : OTH1[f]]));
                qe = $signed({2'b00, quot[f][k]});
                r_pt[f][k] <= r_dl[DIV_LAT-1].face[f].neg[k] ? oe - qe : oe + qe;
            end
        end
    end

    // stage 5: bounds check, candidates
    t_cand n_cand [0:NFACE-1];
    t_cand r_cand [0:NFACE-1];

    always_comb begin
        logic signed [PTW-1:0] l0, h0, l1, h1;
        logic                  in0, in1;
        for (int f = 0; f < NFACE; f++) begin
            l0  = PTW'(r_lo[OTH0[f]]);
            h0  = PTW'(r_hi[OTH0[f]]);
            l1  = PTW'(r_lo[OTH1[f]]);
            h1  = PTW'(r_hi[OTH1[f]]);
            in0 = (l0 < r_pt[f][0]) && (r_pt[f][0] < h0);
            in1 = (l1 < r_pt[f][1]) && (r_pt[f][1] < h1);
            n_cand[f].v    = !r_side4.face[f].skip && in0 && in1;
            n_cand[f].nneg = r_side4.face[f].nneg;
            n_cand[f].nmag = r_side4.face[f].nmag;
            n_cand[f].den  = r_side4.face[f].den;
            n_cand[f].pt[AXIS[f]] = (f < 3) ? r_lo[AXIS[f]] : r_hi[AXIS[f]];
            n_cand[f].pt[OTH0[f]] = r_pt[f][0][DW-1:0];
            n_cand[f].pt[OTH1[f]] = r_pt[f][1][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    // compare tree, level 1: pairs (0,1) (2,3) (4,5)
    t_cand         r_l1_a  [0:2];
    t_cand         r_l1_b  [0:2];
    logic [PW-1:0] r_l1_m1 [0:2];
    logic [PW-1:0] r_l1_m2 [0:2];
    t_cand         r_w     [0:2];

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < 3; p++) begin
            r_l1_a[p]  <= r_cand[2*p];
            r_l1_b[p]  <= r_cand[2*p+1];
            r_l1_m1[p] <= r_cand[2*p+1].nmag * r_cand[2*p].den;
            r_l1_m2[p] <= r_cand[2*p].nmag * r_cand[2*p+1].den;
        end
        for (int p = 0; p < 3; p++) begin
            r_w[p] <= pick(r_l1_a[p], r_l1_b[p], r_l1_m1[p], r_l1_m2[p]);
        end
    end

    // level 2: (w0,w1), w2 waits
    t_cand         r_l2_a, r_l2_b, r_l2_c, r_x, r_x2;
    logic [PW-1:0] r_l2_m1, r_l2_m2;

    always_ff @(posedge i_clk) begin
        r_l2_a  <= r_w[0];
        r_l2_b  <= r_w[1];
        r_l2_c  <= r_w[2];
        r_l2_m1 <= r_w[1].nmag * r_w[0].den;
        r_l2_m2 <= r_w[0].nmag * r_w[1].den;
        r_x     <= pick(r_l2_a, r_l2_b, r_l2_m1, r_l2_m2);
        r_x2    <= r_l2_c;
    end

    // level 3: final
    t_cand         r_l3_a, r_l3_b, r_out;
    logic [PW-1:0] r_l3_m1, r_l3_m2;

    always_ff @(posedge i_clk) begin
        r_l3_a  <= r_x;
        r_l3_b  <= r_x2;
        r_l3_m1 <= r_x2.nmag * r_x.den;
        r_l3_m2 <= r_x.nmag * r_x2.den;
        r_out   <= pick(r_l3_a, r_l3_b, r_l3_m1, r_l3_m2);
    end

    assign o_done  = r_done;
    assign o_hit   = r_done && r_out.v;
    assign o_hit_x = r_out.v ? $signed(r_out.pt[0]) : '0;
    assign o_hit_y = r_out.v ? $signed(r_out.pt[1]) : '0;
    assign o_hit_z = r_out.v ? $signed(r_out.pt[2]) : '0;

`ifndef SYNTH
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("result word missing after pipeline latency");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, LAT)) |-> $past(i_start, LAT))
        else $error("result word without an accepted ray");

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_hit_x == '0 && o_hit_y == '0 && o_hit_z == '0))
        else $error("miss word with nonzero point");
`endif

endmodule
`default_nettype wire

// File: rtl/core/rbi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbi_div
// Pipelined restoring divider: entry stage, then one quotient bit per stage.
// Quotient is clamped to 2^34; anything at or above it leaves the box anyway.
// ----------------------------------------------------------------------------
module rbi_div import rbi_pkg::*; (
    input  logic          i_clk,
    input  logic [PW-1:0] i_prod,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quot
);

    logic [RW-1:0] r_rem [0:QB-1];
    logic [DW-1:0] r_den [0:QB-1];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_sat [0:QB];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(i_prod);
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_sat[0] <= RW'(i_prod) >= (RW'(i_den) << QB);
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        localparam int K = QB - s;
        logic [RW-1:0] sub_k;
        logic          ge_k;

        always_comb begin
            sub_k = RW'(r_den[s-1]) << K;
            ge_k  = r_rem[s-1] >= sub_k;
        end

        always_ff @(posedge i_clk) begin
            r_sat[s] <= r_sat[s-1];
            r_q[s]   <= r_q[s-1] | (QB'(ge_k) << K);
        end

        if (s < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_den[s] <= r_den[s-1];
                r_rem[s] <= ge_k ? r_rem[s-1] - sub_k : r_rem[s-1];
            end
        end
    end

    assign o_quot = (r_sat[QB] || r_q[QB][QB-1]) ? QCLAMP : r_q[QB];

endmodule
`default_nettype wire

// File: test/ray_box_intersection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_intersection_test
// Self-checking bench: directed and random rays against several box settings,
// each result word compared with an in-bench prediction of the crossing point.
// ----------------------------------------------------------------------------
module ray_box_intersection_test;
    import rbi_pkg::*;

    typedef struct {
        logic        hit;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point_word;

    class crossing_board;
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        t_point_word        pending [$];
        int                 errors;

        function new();
            foreach (lo[k]) begin
                lo[k] = '0;
                hi[k] = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MIN_X: lo[0] = data;
                CFG_MIN_Y: lo[1] = data;
                CFG_MIN_Z: lo[2] = data;
                CFG_MAX_X: hi[0] = data;
                CFG_MAX_Y: hi[1] = data;
                CFG_MAX_Z: hi[2] = data;
                default: ;
            endcase
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        function logic [31:0] sat(longint v);
            if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
            if (v < -64'sh80000000) v = -64'sh80000000;
            return v[31:0];
        endfunction

        // a1*b1 > a2*b2 with b >= 0
        function bit farther(longint a1, longint b1, longint a2, longint b2);
            longint unsigned m1;
            longint unsigned m2;
            bit n1;
            bit n2;
            m1 = mag(a1) * longint'(b1);
            m2 = mag(a2) * longint'(b2);
            n1 = a1 < 0 && m1 != 0;
            n2 = a2 < 0 && m2 != 0;
            if (n1 != n2) return n2;
            if (!n1) return m1 > m2;
            return m1 < m2;
        endfunction

        function void note_ray(logic signed [31:0] d [3], logic signed [31:0] o [3]);
            longint best [3];
            longint pt [3];
            longint best_n;
            longint best_d;
            longint face;
            longint num;
            longint den;
            longint unsigned q;
            bit found;
            bit in_box;
            bit neg;
            int ax;
            t_point_word w;
            best = '{0, 0, 0};
            best_n = 0;
            best_d = 1;
            found = 0;
            for (int f = 0; f < 6; f++) begin
                ax = f % 3;
                if (d[ax] == 0) continue;
                face = f < 3 ? longint'(lo[ax]) : longint'(hi[ax]);
                num = face - longint'(o[ax]);
                den = longint'(d[ax]);
                if (den < 0) begin
                    num = -num;
                    den = -den;
                end
                pt[ax] = face;
                in_box = 1;
                for (int j = 0; j < 3; j++) begin
                    if (j == ax) continue;
                    q = mag(longint'(d[j])) * mag(num) / longint'(den);
                    if (q > 64'd17179869184) q = 64'd17179869184;
                    neg = (d[j] < 0) != (num < 0);
                    pt[j] = neg ? longint'(o[j]) - longint'(q) : longint'(o[j]) + longint'(q);
                    if (!(longint'(lo[j]) < pt[j] && pt[j] < longint'(hi[j]))) in_box = 0;
                end
                if (!in_box) continue;
                if (!found || farther(num, best_d, best_n, den)) begin
                    found = 1;
                    best_n = num;
                    best_d = den;
                    best = pt;
                end
            end
            w.hit = found;
            w.x = found ? sat(best[0]) : '0;
            w.y = found ? sat(best[1]) : '0;
            w.z = found ? sat(best[2]) : '0;
            pending = {pending, w};
        endfunction

        function void check_word(logic hit, logic [31:0] x, logic [31:0] y, logic [31:0] z);
            t_point_word w;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (hit !== w.hit) begin
                $error("hit: expected %0b actual %0b", w.hit, hit);
                errors++;
            end
            if (x !== w.x) begin
                $error("hit_x: expected %h actual %h", w.x, x);
                errors++;
            end
            if (y !== w.y) begin
                $error("hit_y: expected %h actual %h", w.y, y);
                errors++;
            end
            if (z !== w.z) begin
                $error("hit_z: expected %h actual %h", w.z, z);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [31:0] i_dir_x, i_dir_y, i_dir_z;
    logic signed [31:0] i_org_x, i_org_y, i_org_z;
    logic               i_cfg_we;
    logic [CFG_IW-1:0]  i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               o_done;
    logic               o_hit;
    logic signed [31:0] o_hit_x, o_hit_y, o_hit_z;

    crossing_board board;
    int            idle_pct;
    int            quiet_cycles;

    ray_box_intersection u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_org_x(i_org_x), .i_org_y(i_org_y), .i_org_z(i_org_z),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_hit(o_hit),
        .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_hit_z(o_hit_z)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_word(o_hit, o_hit_x, o_hit_y, o_hit_z);
        end
        if ((i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000) begin
            $display("ray_box_intersection verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                           logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
        write_reg(CFG_MIN_X, x0);
        write_reg(CFG_MIN_Y, y0);
        write_reg(CFG_MIN_Z, z0);
        write_reg(CFG_MAX_X, x1);
        write_reg(CFG_MAX_Y, y1);
        write_reg(CFG_MAX_Z, z1);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_ray(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        logic signed [31:0] d [3];
        logic signed [31:0] o [3];
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_dir_x <= dx; i_dir_y <= dy; i_dir_z <= dz;
        i_org_x <= ox; i_org_y <= oy; i_org_z <= oz;
        d = '{dx, dy, dz};
        o = '{ox, oy, oz};
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_busy;
        end
        board.note_ray(d, o);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h0;
            default: return 32'($signed($urandom_range(2 * 2 ** 21)) - 2 ** 21);
        endcase
    endfunction

    function automatic logic [31:0] step();
        case ($urandom_range(9))
            0: return $urandom();
            1, 2: return 32'h0;
            3: return 32'($signed($urandom_range(2 * 2 ** 16)) - 2 ** 16);
            default: return 32'($signed($urandom_range(2 * 2 ** 20)) - 2 ** 20);
        endcase
    endfunction

    task automatic random_rays(int count);
        for (int n = 0; n < count; n++) begin
            send_ray(step(), step(), step(), coord(), coord(), coord());
        end
    endtask

    task automatic random_box();
        logic [31:0] a [3];
        logic [31:0] b [3];
        for (int k = 0; k < 3; k++) begin
            a[k] = 32'($signed($urandom_range(2 ** 20)) - 2 ** 20);
            b[k] = 32'($signed($urandom_range(2 ** 20)));
        end
        set_box(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    initial begin
        board = new();
        idle_pct = 8;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        {i_dir_x, i_dir_y, i_dir_z, i_org_x, i_org_y, i_org_z} = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset box is empty: every ray misses
        send_ray(32'h10000, 32'h10000, 32'h10000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000);
        send_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        set_box(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'h10000, 32'h10000, 32'h10000);
        send_ray(32'h10000, 32'h0, 32'h0, 32'hFFFD0000, 32'h0, 32'h0);
        send_ray(32'h0, 32'h10000, 32'h0, 32'h0, 32'hFFFD0000, 32'h0);
        send_ray(32'h0, 32'h0, 32'hFFFF0000, 32'h0, 32'h0, 32'h30000);
        // origin beyond the box, pointing away
        send_ray(32'h10000, 32'h0, 32'h0, 32'h50000, 32'h8000, 32'h0);
        send_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_ray(32'h10000, 32'h10000, 32'h0, 32'hFFFD0000, 32'hFFFD0000, 32'h0);
        send_ray(32'h10000, 32'h10001, 32'h0, 32'hFFFE0000, 32'hFFFE0000, 32'h0);
        send_ray(32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h0, 32'h0, 32'h0);
        send_ray(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000);
        send_ray(32'h1, 32'h1, 32'h1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_ray(32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h8000, 32'hFFFF8000);
        send_ray(32'h30000, 32'h20000, 32'h10000, 32'h0, 32'h0, 32'h0);
        drain();

        // out-of-range indexes are ignored
        write_reg(3'd6, 32'hFFFFFFFF);
        write_reg(3'd7, 32'h12345678);
        set_box(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_ray(32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h80000000);
        random_rays(60);
        drain();

        // inverted box
        set_box(32'h10000, 32'h0, 32'h0, 32'hFFFF0000, 32'h40000, 32'h40000);
        random_rays(40);
        drain();

        random_box();
        random_rays(200);
        drain();

        idle_pct = 70;
        set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_rays(50);
        drain();
        random_box();
        random_rays(150);
        drain();

        idle_pct = 0;
        random_box();
        random_rays(230);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("ray_box_intersection verification clean");
        end else begin
            $display("ray_box_intersection verification failed");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/rbi_pkg.sv
rtl/core/rbi_div.sv
rtl/core/ray_box_intersection.sv
test/ray_box_intersection_test.sv
